/* rtl/point_set_key_sorter_assert.svh */
// ----------------------------------------------------------------------------
// point_set_key_sorter_assert.svh
// Assertion macros used by the sorter top-level file.
// ----------------------------------------------------------------------------
`ifndef POINT_SET_KEY_SORTER_ASSERT_SVH
`define POINT_SET_KEY_SORTER_ASSERT_SVH

// same-cycle implication
`define PSKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point_set_key_sorter: same-cycle check failed");

// next-cycle implication
`define PSKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("point_set_key_sorter: next-cycle check failed");

`endif

/* rtl/psks_pkg.sv */
// ----------------------------------------------------------------------------
// psks_pkg
// Types and codes shared by the point set key sorter modules.
// ----------------------------------------------------------------------------
package psks_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SORT_KEY  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ASCENDING = 1'b1;

  localparam logic [1:0] KEY_X  = 2'd0;
  localparam logic [1:0] KEY_Y  = 2'd1;
  localparam logic [1:0] KEY_Z  = 2'd2;
  localparam logic [1:0] KEY_L1 = 2'd3;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_PLACE = 3'b100
  } psks_state_e;

  typedef struct packed {
    logic wr_point;
    logic drop_point;
    logic start_scan;
    logic issue;
    logic place;
  } psks_cmd_t;

  typedef struct packed {
    logic store_full;
    logic issue_done;
    logic pipe_empty;
    logic best_valid;
    logic out_free;
    logic last_place;
  } psks_sts_t;

endpackage

/* rtl/psks_ctrl.sv */
// ----------------------------------------------------------------------------
// psks_ctrl
// Controller: load, selection scan and result placement sequencing.
// ----------------------------------------------------------------------------
module psks_ctrl import psks_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      set_end_i,
  output logic      in_ready_o,
  input  psks_sts_t sts_i,
  output psks_cmd_t cmd_o
);

  psks_state_e state_q, state_d;
  logic        in_xfer;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o            = '0;
    state_d          = state_q;
    cmd_o.wr_point   = in_xfer && !sts_i.store_full;
    cmd_o.drop_point = in_xfer && sts_i.store_full;
    case (state_q)
      ST_LOAD: begin
        if (in_xfer && set_end_i) begin
          cmd_o.start_scan = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = !sts_i.issue_done;
        if (sts_i.issue_done && sts_i.pipe_empty) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (sts_i.out_free) begin
          cmd_o.place = 1'b1;
          if (sts_i.last_place) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.start_scan = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/psks_dp.sv */
// ----------------------------------------------------------------------------
// psks_dp
// Datapath: point store, key pipeline, best-candidate register, result register.
// ----------------------------------------------------------------------------
module psks_dp import psks_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [CfgDataW-1:0]          cfg_data_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] pz_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] qx_o,
  output logic signed [COORD_BITS-1:0] qy_o,
  output logic signed [COORD_BITS-1:0] qz_o,
  output logic                         final_point_o,
  output logic                         overflowed_o,
  input  psks_cmd_t                    cmd_i,
  output psks_sts_t                    sts_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned PW    = 3 * COORD_BITS;
  localparam int unsigned KW    = COORD_BITS + 2;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);

  logic [1:0]       sort_key_q;
  logic             ascending_q;
  logic [CNT_W-1:0] count_q, rd_idx_q, emit_cnt_q;
  logic             drop_q;
  logic [MAX_POINTS-1:0] used_q;

  logic [PW-1:0]    mem [MAX_POINTS];
  logic [PW-1:0]    rd_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, best_idx_q;
  logic             v1_q, v2_q, best_valid_q;
  logic signed [KW-1:0] key2_q, best_key_q;
  logic [PW-1:0]    pt2_q, best_pt_q, out_pt_q;
  logic             out_valid_q, out_final_q, out_ovf_q;

  logic signed [KW-1:0] kx, ky, kz, ax, ay, az, key_d;
  logic             beats, take;

  // key of the point coming out of the store
  assign kx = {{2{rd_q[CW-1]}}, rd_q[CW-1:0]};
  assign ky = {{2{rd_q[2*CW-1]}}, rd_q[2*CW-1:CW]};
  assign kz = {{2{rd_q[PW-1]}}, rd_q[PW-1:2*CW]};
  assign ax = kx[KW-1] ? -kx : kx;
  assign ay = ky[KW-1] ? -ky : ky;
  assign az = kz[KW-1] ? -kz : kz;

  always_comb begin
    case (sort_key_q)
      KEY_X:   key_d = kx;
      KEY_Y:   key_d = ky;
      KEY_Z:   key_d = kz;
      KEY_L1:  key_d = ax + ay + az;
      default: key_d = kx;
    endcase
  end

  // strict compare keeps the earliest arrival on equal keys
  assign beats = ascending_q ? (key2_q < best_key_q) : (key2_q > best_key_q);
  assign take  = v2_q && (!best_valid_q || beats);

  assign sts_o.store_full = (count_q == CNT_W'(MAX_POINTS));
  assign sts_o.issue_done = (rd_idx_q == count_q);
  assign sts_o.pipe_empty = !v1_q && !v2_q;
  assign sts_o.best_valid = best_valid_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.last_place = ((emit_cnt_q + CNT_W'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_key_q   <= KEY_X;
      ascending_q  <= 1'b1;
      count_q      <= '0;
      rd_idx_q     <= '0;
      emit_cnt_q   <= '0;
      drop_q       <= 1'b0;
      used_q       <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      best_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SORT_KEY:  sort_key_q  <= cfg_data_i;
          CFG_ASCENDING: ascending_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.wr_point) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.drop_point) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.start_scan) begin
        rd_idx_q     <= '0;
        best_valid_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (take) begin
          best_valid_q <= 1'b1;
        end
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q && !used_q[idx1_q];
      if (cmd_i.place) begin
        out_valid_q <= 1'b1;
        if (sts_o.last_place) begin
          count_q    <= '0;
          emit_cnt_q <= '0;
          drop_q     <= 1'b0;
          used_q     <= '0;
        end else begin
          emit_cnt_q         <= emit_cnt_q + CNT_W'(1);
          used_q[best_idx_q] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_point) begin
      mem[count_q[IDX_W-1:0]] <= {pz_i, py_i, px_i};
    end
    rd_q   <= mem[rd_idx_q[IDX_W-1:0]];
    idx1_q <= rd_idx_q[IDX_W-1:0];
    idx2_q <= idx1_q;
    pt2_q  <= rd_q;
    key2_q <= key_d;
    if (take) begin
      best_key_q <= key2_q;
      best_pt_q  <= pt2_q;
      best_idx_q <= idx2_q;
    end
    if (cmd_i.place) begin
      out_pt_q    <= best_pt_q;
      out_final_q <= sts_o.last_place;
      out_ovf_q   <= drop_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign qx_o          = out_pt_q[CW-1:0];
  assign qy_o          = out_pt_q[2*CW-1:CW];
  assign qz_o          = out_pt_q[PW-1:2*CW];
  assign final_point_o = out_final_q;
  assign overflowed_o  = out_ovf_q;

endmodule

/* rtl/point_set_key_sorter.sv */
// ----------------------------------------------------------------------------
// point_set_key_sorter
// Stable sort of a set of 3D points by x, y, z or L1 distance.
//
// Points load one per cycle until the point flagged set_end; up to MAX_POINTS
// are kept and later ones are dropped, which flags every result of that set.
// The set then streams out sorted, one result at a time, equal keys in arrival
// order. Each result comes from a selection scan over the single-port point
// store, and an output stall holds back the next result. Loading of the next
// set opens once the last result sits in the output register. The key and
// direction in effect when the set is emitted apply.
// ----------------------------------------------------------------------------
`include "point_set_key_sorter_assert.svh"

module point_set_key_sorter import psks_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [CfgDataW-1:0]          cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] pz_i,
  input  logic                         set_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] qx_o,
  output logic signed [COORD_BITS-1:0] qy_o,
  output logic signed [COORD_BITS-1:0] qz_o,
  output logic                         final_point_o,
  output logic                         overflowed_o
);

  psks_cmd_t cmd;
  psks_sts_t sts;

  psks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .set_end_i  (set_end_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psks_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .px_i          (px_i),
    .py_i          (py_i),
    .pz_i          (pz_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .qx_o          (qx_o),
    .qy_o          (qy_o),
    .qz_o          (qz_o),
    .final_point_o (final_point_o),
    .overflowed_o  (overflowed_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  `PSKS_ASSERT_NOW(a_place_has_best, cmd.place, sts.best_valid)
  `PSKS_ASSERT_NEXT(a_last_reopens_load, cmd.place && sts.last_place, in_ready_o)
  `PSKS_ASSERT_NOW(a_load_pipe_idle, in_ready_o, sts.pipe_empty)
  `PSKS_ASSERT_NEXT(a_place_shows_result, cmd.place, out_valid_o)

endmodule
